[design/ncd_pkg.sv]
// Shared constants, types and state codes for the negative cycle detector.
package ncd_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 2048;

  localparam int NODE_W = 10;                       // node index field width
  localparam int WGT_W  = 16;                       // edge weight field width
  localparam int CFG_W  = 11;                       // node_count register width
  localparam int DIST_W = 32;                       // distance width
  localparam int NCNT_W = $clog2(MAX_NODES + 1);    // holds 0..MAX_NODES
  localparam int EIDX_W = $clog2(MAX_EDGES);        // edge table address
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);    // holds 0..MAX_EDGES
  localparam int NADR_W = $clog2(MAX_NODES);        // node store address

  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [WGT_W-1:0]  wgt;
  } edge_t;

  // One node store entry: reachable flag and distance.
  typedef struct packed {
    logic              reach;
    logic [DIST_W-1:0] distance;
  } node_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLEAR,
    S_EREAD,
    S_NREAD,
    S_EVAL,
    S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic edge_wr;    // store the accepted edge beat
    logic total_clr;  // start a new graph
    logic clr_init;   // latch node count, zero clear address and loop counters
    logic clr_wr;     // clear one node store entry
    logic erd;        // read edge table at the current edge index
    logic nrd;        // read both endpoint entries of the fetched edge
    logic apply;      // write back a relaxation
    logic edge_adv;   // step to the next edge, wrapping into the next pass
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic clr_done;   // last node entry is being cleared
    logic edge_end;   // current edge is the last stored one
    logic check;      // all relaxation passes done, this is the check pass
    logic total_zero; // no edges stored
    logic relax;      // fetched edge can relax
  } stat_t;

endpackage

[design/ncd_ctrl.sv]
// Controller state machine: load, clear, relaxation walk and result hand-off.
module ncd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_edge_valid,
  input  logic           in_last_edge,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_cycle_found,
  output ncd_pkg::cmd_t  cmd,
  input  ncd_pkg::stat_t stat
);

  ncd_pkg::state_t state_r, state_nxt;
  logic res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ncd_pkg::S_LOAD;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    cmd           = '0;
    in_ready      = 1'b0;

    // drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ncd_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.edge_wr = in_edge_valid;
          if (in_last_edge) begin
            cmd.clr_init = 1'b1;
            state_nxt    = ncd_pkg::S_CLEAR;
          end
        end
      end
      ncd_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          if (stat.total_zero) begin
            res_nxt   = 1'b0;
            state_nxt = ncd_pkg::S_DONE;
          end else begin
            state_nxt = ncd_pkg::S_EREAD;
          end
        end
      end
      ncd_pkg::S_EREAD: begin
        cmd.erd   = 1'b1;
        state_nxt = ncd_pkg::S_NREAD;
      end
      ncd_pkg::S_NREAD: begin
        cmd.nrd   = 1'b1;
        state_nxt = ncd_pkg::S_EVAL;
      end
      ncd_pkg::S_EVAL: begin
        if (stat.check) begin
          // check pass: stop at the first edge that still relaxes
          if (stat.relax) begin
            res_nxt   = 1'b1;
            state_nxt = ncd_pkg::S_DONE;
          end else if (stat.edge_end) begin
            res_nxt   = 1'b0;
            state_nxt = ncd_pkg::S_DONE;
          end else begin
            cmd.edge_adv = 1'b1;
            state_nxt    = ncd_pkg::S_EREAD;
          end
        end else begin
          cmd.apply    = 1'b1;
          cmd.edge_adv = 1'b1;
          state_nxt    = ncd_pkg::S_EREAD;
        end
      end
      ncd_pkg::S_DONE: begin
        // hand the result to the output stage when it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_r;
          cmd.total_clr = 1'b1;
          state_nxt     = ncd_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = ncd_pkg::S_LOAD;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_cycle_found = out_found_r;

endmodule

[design/ncd_dpath.sv]
// Datapath: edge table, node store, loop counters and relaxation arithmetic.
module ncd_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ncd_pkg::CFG_W-1:0]    cfg_node_count,
  input  logic [ncd_pkg::NODE_W-1:0]   in_source_node,
  input  logic [ncd_pkg::NODE_W-1:0]   in_dest_node,
  input  logic signed [ncd_pkg::WGT_W-1:0] in_edge_weight,
  input  ncd_pkg::cmd_t                cmd,
  output ncd_pkg::stat_t               stat
);

  logic [ncd_pkg::CFG_W-1:0]  node_count_r;
  logic [ncd_pkg::NCNT_W-1:0] nodes_r;
  logic [ncd_pkg::NCNT_W-1:0] nodes_nxt;
  logic [ncd_pkg::ECNT_W-1:0] total_r;
  logic [ncd_pkg::EIDX_W-1:0] edge_idx_r;
  logic [ncd_pkg::NCNT_W-1:0] pass_r;
  logic [ncd_pkg::NADR_W-1:0] clr_addr_r;

  ncd_pkg::edge_t edge_mem [ncd_pkg::MAX_EDGES];
  ncd_pkg::node_t node_mem [ncd_pkg::MAX_NODES];

  ncd_pkg::edge_t e_r;
  ncd_pkg::node_t nu_r;
  ncd_pkg::node_t nv_r;

  logic [ncd_pkg::DIST_W:0]   sum_w;
  logic [ncd_pkg::DIST_W-1:0] cand;
  logic                       u_ok;
  logic                       v_ok;
  logic                       relax;
  logic                       total_full;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= ncd_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      node_count_r <= cfg_node_count;
    end
  end

  // Effective node count: zero reads as one, clamp to the store depth
  always_comb begin
    if (node_count_r == '0) begin
      nodes_nxt = ncd_pkg::NCNT_W'(1);
    end else if (32'(node_count_r) > ncd_pkg::MAX_NODES) begin
      nodes_nxt = ncd_pkg::NCNT_W'(ncd_pkg::MAX_NODES);
    end else begin
      nodes_nxt = ncd_pkg::NCNT_W'(node_count_r);
    end
  end

  assign total_full = (total_r == ncd_pkg::ECNT_W'(ncd_pkg::MAX_EDGES));

  // Edge count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.total_clr) begin
      total_r <= '0;
    end else if (cmd.edge_wr && !total_full) begin
      total_r <= total_r + ncd_pkg::ECNT_W'(1);
    end
  end

  // Loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r    <= ncd_pkg::NCNT_W'(1);
      clr_addr_r <= '0;
      edge_idx_r <= '0;
      pass_r     <= '0;
    end else if (cmd.clr_init) begin
      nodes_r    <= nodes_nxt;
      clr_addr_r <= '0;
      edge_idx_r <= '0;
      pass_r     <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + ncd_pkg::NADR_W'(1);
      end
      if (cmd.edge_adv) begin
        if (stat.edge_end) begin
          edge_idx_r <= '0;
          pass_r     <= pass_r + ncd_pkg::NCNT_W'(1);
        end else begin
          edge_idx_r <= edge_idx_r + ncd_pkg::EIDX_W'(1);
        end
      end
    end
  end

  // Edge table: write on load, registered read during the walk
  always_ff @(posedge clk) begin
    if (cmd.edge_wr && !total_full) begin
      edge_mem[total_r[ncd_pkg::EIDX_W-1:0]] <= '{src: in_source_node,
                                                  dst: in_dest_node,
                                                  wgt: in_edge_weight};
    end
    if (cmd.erd) begin
      e_r <= edge_mem[edge_idx_r];
    end
  end

  // Node store: clear or relax write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      node_mem[clr_addr_r] <= '{reach: (clr_addr_r == '0), distance: '0};
    end else if (cmd.apply && relax) begin
      node_mem[e_r.dst] <= '{reach: 1'b1, distance: cand};
    end
    if (cmd.nrd) begin
      nu_r <= node_mem[e_r.src];
      nv_r <= node_mem[e_r.dst];
    end
  end

  // Saturating candidate distance and relax decision
  always_comb begin
    sum_w = {nu_r.distance[ncd_pkg::DIST_W-1], nu_r.distance}
          + {{(ncd_pkg::DIST_W + 1 - ncd_pkg::WGT_W){e_r.wgt[ncd_pkg::WGT_W-1]}}, e_r.wgt};
    if (sum_w[ncd_pkg::DIST_W] != sum_w[ncd_pkg::DIST_W-1]) begin
      cand = sum_w[ncd_pkg::DIST_W] ? ncd_pkg::DIST_MIN : ncd_pkg::DIST_MAX;
    end else begin
      cand = sum_w[ncd_pkg::DIST_W-1:0];
    end
    u_ok  = ({1'b0, e_r.src} < nodes_r);
    v_ok  = ({1'b0, e_r.dst} < nodes_r);
    relax = u_ok && v_ok && nu_r.reach &&
            (!nv_r.reach || ($signed(cand) < $signed(nv_r.distance)));
  end

  assign stat.clr_done   = ({1'b0, clr_addr_r} == (nodes_r - ncd_pkg::NCNT_W'(1)));
  assign stat.edge_end   = ({1'b0, edge_idx_r} == (total_r - ncd_pkg::ECNT_W'(1)));
  assign stat.check      = (pass_r == nodes_r);
  assign stat.total_zero = (total_r == '0);
  assign stat.relax      = relax;

  // Edge count never passes the table depth
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= ncd_pkg::ECNT_W'(ncd_pkg::MAX_EDGES))
    else $error("edge count beyond table depth");

  // No write-back during the check pass
  a_apply_not_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> !stat.check)
    else $error("relaxation applied during check pass");

  // Clearing stays inside the effective node range
  a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> ({1'b0, clr_addr_r} < nodes_r))
    else $error("clear address beyond node count");

  // Pass counter never runs past the check pass
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r <= nodes_r)
    else $error("pass counter beyond node count");

endmodule

[design/negative_cycle_detector.sv]
// Sequence: after the last beat, the node store is cleared for the N effective nodes, then
// each edge steps through edge read, node read and evaluate in N relaxation passes and up to
// one check pass, which stops at the first edge that still relaxes; then out_valid rises.
// Throughput: one edge beat per cycle while loading; one graph at a time.
// Reset: rst_n synchronous active low; clears edge count, node_count to 1, output stage;
// tables are not reset, the node store is cleared at the start of every run.
module negative_cycle_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ncd_pkg::CFG_W-1:0]        cfg_node_count,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_edge_valid,
  input  logic [ncd_pkg::NODE_W-1:0]       in_source_node,
  input  logic [ncd_pkg::NODE_W-1:0]       in_dest_node,
  input  logic signed [ncd_pkg::WGT_W-1:0] in_edge_weight,
  input  logic                             in_last_edge,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_cycle_found
);

  ncd_pkg::cmd_t  cmd;
  ncd_pkg::stat_t stat;

  // Sequencer
  ncd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_edge_valid   (in_edge_valid),
    .in_last_edge    (in_last_edge),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cycle_found (out_cycle_found),
    .cmd             (cmd),
    .stat            (stat)
  );

  // Storage and arithmetic
  ncd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_node_count (cfg_node_count),
    .in_source_node (in_source_node),
    .in_dest_node   (in_dest_node),
    .in_edge_weight (in_edge_weight),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule
